FILE: src/lge_pkg.sv
// Shared definitions for the life generation engine: field widths, item
// kind codes and the B3/S23 cell rule.
// No dependencies.
`timescale 1ns / 1ps

package lge_pkg;

  // Item field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned POP_W    = 13;
  localparam int unsigned IN_DW    = 16;  // row, col, value, zero fill
  localparam int unsigned OUT_DW   = 16;  // cell_res, population, zero fill
  localparam int unsigned IN_PAD_W = IN_DW - ROW_W - COL_W - 1;
  localparam int unsigned OUT_PAD_W = OUT_DW - 1 - POP_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STEP  = 2'd2
  } kind_e;

  // B3/S23: survive on 2 or 3 neighbors, birth on exactly 3
  function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbrs[i]);
    end
    return alive ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
  endfunction

endpackage

FILE: src/lge_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lge_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lge_row_eval.sv
// Next-generation evaluation of one grid row from the rows above and below.
// Depends on lge_pkg (cell rule). Cells beyond the row ends count as dead.
`timescale 1ns / 1ps

module lge_row_eval #(
  parameter int unsigned COLS = 64
) (
  input  logic [COLS-1:0] above_i,
  input  logic [COLS-1:0] center_i,
  input  logic [COLS-1:0] below_i,
  output logic [COLS-1:0] next_o
);

  logic [COLS+1:0] a_ext;
  logic [COLS+1:0] c_ext;
  logic [COLS+1:0] b_ext;

  // dead border column on each side
  assign a_ext = {1'b0, above_i, 1'b0};
  assign c_ext = {1'b0, center_i, 1'b0};
  assign b_ext = {1'b0, below_i, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    assign next_o[c] = lge_pkg::life_rule(c_ext[c+1],
        {a_ext[c], a_ext[c+1], a_ext[c+2], c_ext[c], c_ext[c+2],
         b_ext[c], b_ext[c+1], b_ext[c+2]});
  end

endmodule

FILE: src/life_generation_engine_core.sv
// Life generation engine: top level with sequencer, row window and result register.
// Depends on lge_pkg, lge_ram, lge_row_eval.
`timescale 1ns / 1ps

// The engine holds a ROWS x COLS grid of one-bit cells in one RAM, one row per
// word, organized as two banks (current generation and scratch). Items arrive
// on the s_axis side: tuser carries the kind (write cell, read cell, advance
// one generation; the unused kind changes nothing), tdata the row, column and
// value. Every item returns exactly one item on the m_axis side with the
// addressed cell and the live population; out-of-grid addresses are ignored
// and return a dead cell. A cell write or read goes from acceptance (RAM read
// issued at acceptance) through the read-modify-write to the result load; an
// out-of-grid access or the unused kind goes straight to the result load. A
// generation step evaluates each row from a three-row window, and its new
// cells are then counted into the population one per cycle. The next item is
// accepted as soon as the previous result sits in the output register, even
// if it has not been taken yet. After reset a clearing pass writes ROWS zero
// rows into the current bank; no item is accepted until that pass ends.

module life_generation_engine_core #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [lge_pkg::IN_DW-1:0]  s_axis_tdata_i,   // row[5:0], col[11:6], value[12]
  input  logic [lge_pkg::KIND_W-1:0] s_axis_tuser_i,   // kind[1:0]
  // result items
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [lge_pkg::OUT_DW-1:0] m_axis_tdata_o    // cell_res[0], population[13:1]
);

  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLS);
  localparam int unsigned AW        = RW + 1;          // bank bit + row
  localparam int unsigned MEM_DEPTH = 2 * (1 << RW);

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_RMW     = 9'b000000100,
    S_OUT     = 9'b000001000,
    S_ST_RD1  = 9'b000010000,
    S_ST_WAIT = 9'b000100000,
    S_ST_ROW  = 9'b001000000,
    S_ST_CNT  = 9'b010000000,
    S_ST_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic                       bank_q, bank_d;     // bank holding current grid
  logic [lge_pkg::POP_W-1:0]  pop_q, pop_d;
  logic [lge_pkg::POP_W-1:0]  acc_q, acc_d;       // population during a step
  logic [RW-1:0]              rcnt_q, rcnt_d;     // row: clear pass and step
  logic [CW-1:0]              ccnt_q, ccnt_d;     // column of the pop count
  logic                       out_valid_q, out_valid_d;

  // item payload and datapath
  lge_pkg::kind_e             kind_q, kind_d;
  logic [lge_pkg::ROW_W-1:0]  row_q, row_d;
  logic [lge_pkg::COL_W-1:0]  col_q, col_d;
  logic                       val_q, val_d;
  logic                       inside_q, inside_d;
  logic                       res_cell_q, res_cell_d;
  logic [COLS-1:0]            prev_q, prev_d;
  logic [COLS-1:0]            cur_q, cur_d;
  logic [COLS-1:0]            next_q, next_d;
  logic [COLS-1:0]            shift_q, shift_d;
  logic                       out_cell_q, out_cell_d;
  logic [lge_pkg::POP_W-1:0]  out_pop_q, out_pop_d;

  // RAM ports
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [COLS-1:0]            mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [COLS-1:0]            mem_rdata;

  // input fields
  logic [lge_pkg::ROW_W-1:0]  in_row;
  logic [lge_pkg::COL_W-1:0]  in_col;
  logic                       in_val;
  lge_pkg::kind_e             in_kind;
  logic                       in_accept;
  logic                       in_inside;

  logic [CW-1:0]              col_idx;
  logic [COLS-1:0]            new_row;
  logic [COLS-1:0]            rmw_word;
  logic                       old_cell;
  logic                       has_r2;             // row r+2 exists

  assign in_row  = s_axis_tdata_i[lge_pkg::ROW_W-1:0];
  assign in_col  = s_axis_tdata_i[lge_pkg::ROW_W +: lge_pkg::COL_W];
  assign in_val  = s_axis_tdata_i[lge_pkg::ROW_W + lge_pkg::COL_W];
  assign in_kind = lge_pkg::kind_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_inside       = (int'(in_row) < int'(ROWS)) && (int'(in_col) < int'(COLS));

  assign col_idx  = CW'(col_q);
  assign old_cell = mem_rdata[col_idx];
  assign has_r2   = (({1'b0, rcnt_q} + AW'(2)) < AW'(ROWS));

  lge_ram #(
    .WIDTH (COLS),
    .DEPTH (MEM_DEPTH)
  ) u_board (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lge_row_eval #(
    .COLS (COLS)
  ) u_row_eval (
    .above_i  (prev_q),
    .center_i (cur_q),
    .below_i  (next_q),
    .next_o   (new_row)
  );

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    pop_d       = pop_q;
    acc_d       = acc_q;
    rcnt_d      = rcnt_q;
    ccnt_d      = ccnt_q;
    kind_d      = kind_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    inside_d    = inside_q;
    res_cell_d  = res_cell_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    next_d      = next_q;
    shift_d     = shift_q;
    out_cell_d  = out_cell_q;
    out_pop_d   = out_pop_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    mem_we    = 1'b0;
    mem_waddr = {bank_q, rcnt_q};
    mem_wdata = new_row;
    mem_re    = 1'b0;
    mem_raddr = {bank_q, RW'(in_row)};

    rmw_word          = mem_rdata;
    rmw_word[col_idx] = val_q;

    case (state_q)
      S_CLEAR: begin
        // zero the current bank, one row a cycle
        mem_we    = 1'b1;
        mem_waddr = {1'b0, rcnt_q};
        mem_wdata = '0;
        if (rcnt_q == RW'(ROWS - 1)) begin
          rcnt_d  = '0;
          state_d = S_IDLE;
        end else begin
          rcnt_d = rcnt_q + RW'(1);
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          kind_d     = in_kind;
          row_d      = in_row;
          col_d      = in_col;
          val_d      = in_val;
          inside_d   = in_inside;
          res_cell_d = 1'b0;
          case (in_kind)
            lge_pkg::KIND_WRITE, lge_pkg::KIND_READ: begin
              if (in_inside) begin
                mem_re  = 1'b1;
                state_d = S_RMW;
              end else begin
                state_d = S_OUT;
              end
            end
            lge_pkg::KIND_STEP: begin
              mem_re    = 1'b1;
              mem_raddr = {bank_q, {RW{1'b0}}};
              acc_d     = '0;
              rcnt_d    = '0;
              state_d   = S_ST_RD1;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_RMW: begin
        // row word of the addressed cell is on the read port
        if (kind_q == lge_pkg::KIND_WRITE) begin
          mem_we     = 1'b1;
          mem_waddr  = {bank_q, RW'(row_q)};
          mem_wdata  = rmw_word;
          res_cell_d = val_q;
          if (old_cell && !val_q) begin
            pop_d = pop_q - lge_pkg::POP_W'(1);
          end else if (!old_cell && val_q) begin
            pop_d = pop_q + lge_pkg::POP_W'(1);
          end
        end else begin
          res_cell_d = old_cell;
        end
        state_d = S_OUT;
      end

      S_ST_RD1: begin
        prev_d    = '0;
        cur_d     = mem_rdata;              // row 0
        mem_re    = 1'b1;
        mem_raddr = {bank_q, RW'(1)};
        state_d   = S_ST_WAIT;
      end

      S_ST_WAIT: begin
        next_d  = mem_rdata;                // row 1
        state_d = S_ST_ROW;
      end

      S_ST_ROW: begin
        // write new row r into the scratch bank, slide the window
        mem_we    = 1'b1;
        mem_waddr = {~bank_q, rcnt_q};
        mem_wdata = new_row;
        shift_d   = new_row;
        prev_d    = cur_q;
        cur_d     = next_q;
        mem_re    = has_r2;
        mem_raddr = {bank_q, RW'({1'b0, rcnt_q} + AW'(2))};
        ccnt_d    = '0;
        state_d   = S_ST_CNT;
      end

      S_ST_CNT: begin
        if (ccnt_q == '0) begin
          next_d = has_r2 ? mem_rdata : '0;
        end
        acc_d   = acc_q + lge_pkg::POP_W'(shift_q[0]);
        shift_d = shift_q >> 1;
        if (ccnt_q == CW'(COLS - 1)) begin
          if (rcnt_q == RW'(ROWS - 1)) begin
            state_d = S_ST_FIN;
          end else begin
            rcnt_d  = rcnt_q + RW'(1);
            state_d = S_ST_ROW;
          end
        end else begin
          ccnt_d = ccnt_q + CW'(1);
        end
      end

      S_ST_FIN: begin
        bank_d     = ~bank_q;
        pop_d      = acc_q;
        res_cell_d = 1'b0;
        state_d    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_cell_d  = res_cell_q;
          out_pop_d   = pop_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bank_q      <= 1'b0;
      pop_q       <= '0;
      acc_q       <= '0;
      rcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      pop_q       <= pop_d;
      acc_q       <= acc_d;
      rcnt_q      <= rcnt_d;
      ccnt_q      <= ccnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    inside_q   <= inside_d;
    res_cell_q <= res_cell_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    next_q     <= next_d;
    shift_q    <= shift_d;
    out_cell_q <= out_cell_d;
    out_pop_q  <= out_pop_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{lge_pkg::OUT_PAD_W{1'b0}}, out_pop_q, out_cell_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a step never writes into the bank it is reading from
  a_step_writes_scratch: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_ST_ROW) |-> (mem_we && (mem_waddr[AW-1] != bank_q)))
    else $error("step wrote into the current bank");

  // banks swap only at the end of a step
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (bank_q != $past(bank_q)) |-> $past(state_q == S_ST_FIN))
    else $error("bank changed outside step end");

  // population moves only on a cell write or a finished step
  a_pop_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pop_q != $past(pop_q)) |-> ($past(state_q == S_RMW) || $past(state_q == S_ST_FIN)))
    else $error("population changed unexpectedly");

  // a write only reaches the RAM for an in-grid address
  a_rmw_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_RMW) |-> inside_q)
    else $error("cell access outside the grid");

endmodule
